>>> rtl/core/lsrgb_pkg.sv
// ----------------------------------------------------------------------------
// lsrgb_pkg
// Shared types, constants and elaboration-time threshold math for the
// linear-to-sRGB 8-bit pixel encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsrgb_pkg;

    localparam int LIN_W         = 24;
    localparam int NUM_CH        = 3;
    localparam int CODE_W        = 8;
    localparam int PIXEL_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FRAC_MAX      = 20;
    localparam int WIDE_W        = 336;
    localparam int LINEAR_TOP    = 10;
    localparam int CODE_TOP      = 255;
    localparam int LINEAR_SLOPE  = 32946;
    localparam int GAMMA_SCALE   = 269025;
    localparam int GAMMA_OFFSET  = 14025;
    localparam int GAMMA_STEP    = 1000;

    localparam logic [CODE_W-1:0] ALPHA_CODE = 8'hFF;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              clamp_lo;
        logic              clamp_hi;
    } chan_t;

    function automatic logic [WIDE_W-1:0] wide_pow(logic [WIDE_W-1:0] base, int n);
        logic [WIDE_W-1:0] acc;
        acc = WIDE_W'(1);
        for (int i = 0; i < n; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // true when raw value v (0 < v < 2^fb) encodes to code k or above
    function automatic bit reaches_code(longint v, int k, int fb);
        logic [WIDE_W-1:0] lhs;
        logic [WIDE_W-1:0] rhs;
        if (k <= LINEAR_TOP) begin
            lhs = WIDE_W'(v) * WIDE_W'(LINEAR_SLOPE);
            rhs = WIDE_W'(k * 10) << fb;
        end else begin
            lhs = wide_pow(WIDE_W'(v), 5) * wide_pow(WIDE_W'(GAMMA_SCALE), 12);
            rhs = wide_pow(WIDE_W'(GAMMA_STEP * k + GAMMA_OFFSET), 12) << (5 * fb);
        end
        return lhs >= rhs;
    endfunction

    // smallest raw value that reaches code k; 2^fb when none does
    function automatic logic [FRAC_MAX:0] code_threshold(int k, int fb);
        longint lo;
        longint hi;
        longint mid;
        if (k <= 0) begin
            return '0;
        end
        lo = 1;
        hi = longint'(1) << fb;
        if (k >= CODE_TOP) begin
            return hi[FRAC_MAX:0];
        end
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (reaches_code(mid, k, fb)) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return lo[FRAC_MAX:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lsrgb_classify.sv
// ----------------------------------------------------------------------------
// lsrgb_classify
// Input stage: splits the request into channels, flags the clamped ranges
// and keeps the fraction bits for the threshold search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsrgb_classify
    import lsrgb_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [NUM_CH*LIN_W-1:0]               in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [NUM_CH-1:0][FRACTION_BITS-1:0]       out_mag,
    output chan_t [NUM_CH-1:0]                         out_st
);

    logic                                  valid_reg;
    logic [NUM_CH-1:0][FRACTION_BITS-1:0]  mag_reg;
    logic [NUM_CH-1:0][FRACTION_BITS-1:0]  mag_next;
    chan_t [NUM_CH-1:0]                    st_reg;
    chan_t [NUM_CH-1:0]                    st_next;
    logic [LIN_W-1:0]                      raw [NUM_CH];

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            raw[ch]              = in_data[ch*LIN_W +: LIN_W];
            mag_next[ch]         = raw[ch][FRACTION_BITS-1:0];
            st_next[ch].code     = '0;
            st_next[ch].clamp_lo = raw[ch][LIN_W-1] || (raw[ch] == '0);
            st_next[ch].clamp_hi = !raw[ch][LIN_W-1] && (|raw[ch][LIN_W-2:FRACTION_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mag_reg <= mag_next;
            st_reg  <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_mag   = mag_reg;
    assign out_st    = st_reg;

endmodule

`default_nettype wire

>>> rtl/core/lsrgb_search_stage.sv
// ----------------------------------------------------------------------------
// lsrgb_search_stage
// One step of the pipelined threshold search: decides one code bit per
// channel against the threshold table slice for that bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsrgb_search_stage
    import lsrgb_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF,
    parameter int BIT           = CODE_W - 1
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [NUM_CH-1:0][FRACTION_BITS-1:0]  in_mag,
    input  wire chan_t [NUM_CH-1:0]                    in_st,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [NUM_CH-1:0][FRACTION_BITS-1:0]       out_mag,
    output chan_t [NUM_CH-1:0]                         out_st
);

    localparam int THR_W = FRACTION_BITS + 1;

    logic                                  valid_reg;
    logic [NUM_CH-1:0][FRACTION_BITS-1:0]  mag_reg;
    chan_t [NUM_CH-1:0]                    st_reg;
    chan_t [NUM_CH-1:0]                    st_next;
    logic [NUM_CH-1:0]                     take;

    if (BIT == CODE_W - 1) begin : g_top
        localparam logic [THR_W-1:0] THR =
            THR_W'(code_threshold(1 << BIT, FRACTION_BITS));
        always_comb begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                take[ch] = {1'b0, in_mag[ch]} >= THR;
            end
        end
    end else begin : g_tab
        localparam int IDX_W   = CODE_W - 1 - BIT;
        localparam int ENTRIES = 1 << IDX_W;
        logic [THR_W-1:0] thr [ENTRIES];
        for (genvar j = 0; j < ENTRIES; j++) begin : g_thr
            assign thr[j] = THR_W'(code_threshold((j << (BIT + 1)) | (1 << BIT),
                                                  FRACTION_BITS));
        end
        always_comb begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                take[ch] = {1'b0, in_mag[ch]} >= thr[in_st[ch].code[CODE_W-1:BIT+1]];
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            st_next[ch] = in_st[ch];
            if (take[ch]) begin
                st_next[ch].code[BIT] = 1'b1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mag_reg <= in_mag;
            st_reg  <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_mag   = mag_reg;
    assign out_st    = st_reg;

endmodule

`default_nettype wire

>>> rtl/core/linear_to_srgb8_pixel_pack_core.sv
// ----------------------------------------------------------------------------
// linear_to_srgb8_pixel_pack_core
// Encodes a linear RGB pixel (signed fixed point) to a packed 8-bit sRGB
// ARGB word with opaque alpha.
// ----------------------------------------------------------------------------
// One pixel enters per clock when there is no back-pressure, and its word passes
// through the stages in order: one classify stage, eight search stages (one code bit per
// stage, compared against a threshold table built at elaboration, so every
// code equals the floor of 255 times the exact sRGB curve), and one output
// stage that applies the clamps and packs the word. Each stage holds its
// request while the next is full, so empty stages keep accepting while a
// finished word waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none

module linear_to_srgb8_pixel_pack_core
    import lsrgb_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // red_linear[23:0], green_linear[47:24], blue_linear[71:48]
    input  wire logic [NUM_CH*LIN_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // pixel_argb[31:0]
    output logic [PIXEL_W-1:0]              m_tdata
);

    localparam int STAGES = CODE_W + 1;

    logic                                  st_valid [STAGES];
    logic                                  st_ready [STAGES];
    logic [NUM_CH-1:0][FRACTION_BITS-1:0]  st_mag   [STAGES];
    chan_t [NUM_CH-1:0]                    st_chan  [STAGES];

    logic                                  out_valid_reg;
    logic [PIXEL_W-1:0]                    pixel_reg;
    logic [PIXEL_W-1:0]                    pixel_next;
    logic                                  out_ready;
    logic [CODE_W-1:0]                     code_final [NUM_CH];

    lsrgb_classify #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_classify (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .out_valid(st_valid[0]),
        .out_ready(st_ready[0]),
        .out_mag  (st_mag[0]),
        .out_st   (st_chan[0])
    );

    for (genvar s = 1; s < STAGES; s++) begin : g_search
        lsrgb_search_stage #(
            .FRACTION_BITS(FRACTION_BITS),
            .BIT          (CODE_W - s)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (st_valid[s-1]),
            .in_ready (st_ready[s-1]),
            .in_mag   (st_mag[s-1]),
            .in_st    (st_chan[s-1]),
            .out_valid(st_valid[s]),
            .out_ready(st_ready[s]),
            .out_mag  (st_mag[s]),
            .out_st   (st_chan[s])
        );
    end

    assign out_ready              = !out_valid_reg || m_tready;
    assign st_ready[STAGES-1]     = out_ready;

    // apply clamps, red in the byte just below the alpha byte
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (st_chan[STAGES-1][ch].clamp_lo) begin
                code_final[ch] = '0;
            end else if (st_chan[STAGES-1][ch].clamp_hi) begin
                code_final[ch] = '1;
            end else begin
                code_final[ch] = st_chan[STAGES-1][ch].code;
            end
        end
        pixel_next = {ALPHA_CODE, code_final[0], code_final[1], code_final[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= st_valid[STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_valid[STAGES-1] && out_ready) begin
            pixel_reg <= pixel_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pixel_reg;

    a_alpha_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PIXEL_W-1 -: CODE_W] == ALPHA_CODE))
        else $error("alpha byte is not opaque");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire
